// ----- hdl/tsrm_pkg.sv -----
// Shared types, register-file addresses, command codes and reset values
// for the temperature monitor register map. No dependencies.
package tsrm_pkg;

  localparam int AddrW = 4;
  localparam int Depth = 16;

  typedef logic [AddrW-1:0] addr_t;

  // register file entries, one byte each
  localparam addr_t A_CONFIG  = 4'd0;
  localparam addr_t A_CONV    = 4'd1;
  localparam addr_t A_LHL     = 4'd2;
  localparam addr_t A_LLL     = 4'd3;
  localparam addr_t A_RHL_HI  = 4'd4;
  localparam addr_t A_RHL_LO  = 4'd5;
  localparam addr_t A_RLL_HI  = 4'd6;
  localparam addr_t A_RLL_LO  = 4'd7;
  localparam addr_t A_ROFF_HI = 4'd8;
  localparam addr_t A_ROFF_LO = 4'd9;
  localparam addr_t A_LCRIT   = 4'd10;
  localparam addr_t A_RCRIT   = 4'd11;
  localparam addr_t A_HYST    = 4'd12;
  localparam addr_t A_DIODE   = 4'd13;
  localparam addr_t A_REPLY   = 4'd14;

  // command codes
  localparam logic [7:0] C_LOCAL_TEMP    = 8'h00;
  localparam logic [7:0] C_REMOTE_TEMP   = 8'h01;
  localparam logic [7:0] C_STATUS        = 8'h02;
  localparam logic [7:0] C_RD_CONFIG     = 8'h03;
  localparam logic [7:0] C_RD_CONV       = 8'h04;
  localparam logic [7:0] C_RD_LHL        = 8'h05;
  localparam logic [7:0] C_RD_LLL        = 8'h06;
  localparam logic [7:0] C_RD_RHL_HI     = 8'h07;
  localparam logic [7:0] C_RD_RLL_HI     = 8'h08;
  localparam logic [7:0] C_WR_CONFIG     = 8'h09;
  localparam logic [7:0] C_WR_CONV       = 8'h0A;
  localparam logic [7:0] C_WR_LHL        = 8'h0B;
  localparam logic [7:0] C_WR_LLL        = 8'h0C;
  localparam logic [7:0] C_WR_RHL_HI     = 8'h0D;
  localparam logic [7:0] C_WR_RLL_HI     = 8'h0E;
  localparam logic [7:0] C_REMOTE_FRAC   = 8'h10;
  localparam logic [7:0] C_ROFF_HI       = 8'h11;
  localparam logic [7:0] C_ROFF_LO       = 8'h12;
  localparam logic [7:0] C_RHL_LO        = 8'h13;
  localparam logic [7:0] C_RLL_LO        = 8'h14;
  localparam logic [7:0] C_RCRIT         = 8'h19;
  localparam logic [7:0] C_LCRIT         = 8'h20;
  localparam logic [7:0] C_HYST          = 8'h21;
  localparam logic [7:0] C_DIODE         = 8'hBF;
  localparam logic [7:0] C_ONE_SHOT      = 8'hF0;
  localparam logic [7:0] C_MFR_ID        = 8'hFE;
  localparam logic [7:0] C_DEV_ID        = 8'hFF;

  localparam logic [7:0] MFR_ID_VAL = 8'h01;
  localparam logic [7:0] DEV_ID_VAL = 8'h21;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_CONST,
    OP_LOAD_MEM,
    OP_STORE,
    OP_DELIVER
  } op_t;

  typedef struct packed {
    op_t        op;
    addr_t      addr;
    logic [7:0] value;
  } dec_t;

  function automatic logic [7:0] reset_val(addr_t a);
    logic [7:0] v;
    v = 8'h00;
    case (a)
      A_LHL:    v = 8'h46;
      A_RHL_HI: v = 8'h46;
      A_RLL_HI: v = 8'h46;
      A_LCRIT:  v = 8'h55;
      A_RCRIT:  v = 8'h55;
      A_HYST:   v = 8'h0a;
      default:  v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/tsrm_decode.sv -----
// Command decoder: turns one bus transaction into a register-file action.
// Depends on tsrm_pkg.
module tsrm_decode (
  input  logic          cmd,
  input  logic [7:0]    length,
  input  logic [7:0]    command_code,
  input  logic [7:0]    data_byte,
  input  logic [15:0]   local_temp,
  input  logic [15:0]   remote_temp,
  input  logic          pending,
  output tsrm_pkg::dec_t dec
);
  import tsrm_pkg::*;

  logic has_data;
  logic exact;

  assign has_data = length >= 8'd2;
  assign exact    = length == 8'd2;

  // byte registers that are written with exactly two bytes, read back otherwise
  function automatic dec_t rw_byte(logic ex, addr_t a, logic [7:0] d);
    dec_t r;
    r.op    = ex ? OP_STORE : OP_LOAD_MEM;
    r.addr  = a;
    r.value = d;
    return r;
  endfunction

  always_comb begin
    dec.op    = OP_NONE;
    dec.addr  = A_REPLY;
    dec.value = data_byte;
    if (cmd) begin
      if (pending && length != 8'd0) dec.op = OP_DELIVER;
    end else if (length != 8'd0) begin
      unique case (command_code)
        C_LOCAL_TEMP: begin
          dec.op = OP_LOAD_CONST; dec.value = local_temp[15:8];
        end
        C_REMOTE_TEMP: begin
          dec.op = OP_LOAD_CONST; dec.value = remote_temp[15:8];
        end
        C_STATUS: begin
          dec.op = OP_LOAD_CONST; dec.value = 8'h00;
        end
        C_REMOTE_FRAC: begin
          dec.op = OP_LOAD_CONST; dec.value = remote_temp[7:0];
        end
        C_MFR_ID: begin
          dec.op = OP_LOAD_CONST; dec.value = MFR_ID_VAL;
        end
        C_DEV_ID: begin
          dec.op = OP_LOAD_CONST; dec.value = DEV_ID_VAL;
        end
        C_RD_CONFIG: begin dec.op = OP_LOAD_MEM; dec.addr = A_CONFIG; end
        C_RD_CONV:   begin dec.op = OP_LOAD_MEM; dec.addr = A_CONV;   end
        C_RD_LHL:    begin dec.op = OP_LOAD_MEM; dec.addr = A_LHL;    end
        C_RD_LLL:    begin dec.op = OP_LOAD_MEM; dec.addr = A_LLL;    end
        C_RD_RHL_HI: begin dec.op = OP_LOAD_MEM; dec.addr = A_RHL_HI; end
        C_RD_RLL_HI: begin dec.op = OP_LOAD_MEM; dec.addr = A_RLL_HI; end
        C_WR_CONFIG: begin dec.op = has_data ? OP_STORE : OP_NONE; dec.addr = A_CONFIG; end
        C_WR_CONV:   begin dec.op = has_data ? OP_STORE : OP_NONE; dec.addr = A_CONV;   end
        C_WR_LHL:    begin dec.op = has_data ? OP_STORE : OP_NONE; dec.addr = A_LHL;    end
        C_WR_LLL:    begin dec.op = has_data ? OP_STORE : OP_NONE; dec.addr = A_LLL;    end
        C_WR_RHL_HI: begin dec.op = has_data ? OP_STORE : OP_NONE; dec.addr = A_RHL_HI; end
        C_WR_RLL_HI: begin dec.op = has_data ? OP_STORE : OP_NONE; dec.addr = A_RLL_HI; end
        C_ROFF_HI: dec = rw_byte(exact, A_ROFF_HI, data_byte);
        C_ROFF_LO: dec = rw_byte(exact, A_ROFF_LO, data_byte);
        C_RHL_LO:  dec = rw_byte(exact, A_RHL_LO, data_byte);
        C_RLL_LO:  dec = rw_byte(exact, A_RLL_LO, data_byte);
        C_RCRIT:   dec = rw_byte(exact, A_RCRIT, data_byte);
        C_LCRIT:   dec = rw_byte(exact, A_LCRIT, data_byte);
        C_HYST:    dec = rw_byte(exact, A_HYST, data_byte);
        C_DIODE:   dec = rw_byte(exact, A_DIODE, data_byte);
        C_ONE_SHOT: dec.op = OP_NONE;
        default:   dec.op = OP_NONE;
      endcase
    end
  end

endmodule

// ----- hdl/temp_sensor_smbus_register_map.sv -----
// Top level of the temperature monitor register map: handshakes, byte
// register file (one synchronous RAM) and result register.
// Depends on tsrm_pkg and tsrm_decode.
//
//   channel | direction | signals
//   --------+-----------+-----------------------------------------------------
//   in      | to block  | in_valid/in_ready, cmd, length, command_code,
//           |           | data_byte, local_temp, remote_temp
//   out     | from block| out_valid/out_ready, returned_count, read_byte
//
// Each transfer has two steps: the accept cycle issues the RAM read, and the
// ST_EXEC state then writes back and loads the result register. The RAM
// read is registered, hence the split. A held result stalls only ST_EXEC.
// Reset clears the per-entry valid bits; an entry not yet written reads as
// its reset value, so no clearing pass is needed.
module temp_sensor_smbus_register_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  length,
  input  logic [7:0]  command_code,
  input  logic [7:0]  data_byte,
  input  logic [15:0] local_temp,
  input  logic [15:0] remote_temp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  returned_count,
  output logic [7:0]  read_byte
);
  import tsrm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t     state;
  state_t     state_next;
  dec_t       dec;
  dec_t       dec_q;
  logic       cmd_q;
  logic [7:0] len_q;
  logic       pending;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] vld;
  logic [7:0]       mem_q;
  logic             vld_q;
  addr_t            rd_addr_q;
  logic [7:0]       rd_data;

  logic       accept;
  logic       go;
  logic       wr_en;
  addr_t      wr_addr;
  logic [7:0] wr_data;

  tsrm_decode u_dec (
    .cmd          (cmd),
    .length       (length),
    .command_code (command_code),
    .data_byte    (data_byte),
    .local_temp   (local_temp),
    .remote_temp  (remote_temp),
    .pending      (pending),
    .dec          (dec)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign go       = (state == ST_EXEC) && (!out_valid || out_ready);
  assign rd_data  = vld_q ? mem_q : reset_val(rd_addr_q);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = A_REPLY;
    wr_data = dec_q.value;
    if (go) begin
      case (dec_q.op)
        OP_STORE: begin
          wr_en = 1'b1; wr_addr = dec_q.addr;
        end
        OP_LOAD_CONST: wr_en = 1'b1;
        OP_LOAD_MEM: begin
          wr_en = 1'b1; wr_data = rd_data;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // RAM: one read port (issued on accept), one write port
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q     <= mem[dec.addr];
      rd_addr_q <= dec.addr;
    end
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= vld[dec.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec_q <= dec;
      cmd_q <= cmd;
      len_q <= length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        if (dec_q.op == OP_DELIVER) begin
          pending <= 1'b0;
        end else if (dec_q.op == OP_LOAD_CONST || dec_q.op == OP_LOAD_MEM) begin
          pending <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (cmd_q) begin
        returned_count <= (dec_q.op == OP_DELIVER) ? 8'd1 : 8'd0;
        read_byte      <= (dec_q.op == OP_DELIVER) ? rd_data : 8'd0;
      end else begin
        returned_count <= len_q;
        read_byte      <= 8'd0;
      end
    end
  end

endmodule
